[src/cell_balance_and_limit_evaluator_unit_assert.svh]
// Assertion macros for the cell balance and limit evaluator.
`ifndef CELL_BALANCE_AND_LIMIT_EVALUATOR_UNIT_ASSERT_SVH
`define CELL_BALANCE_AND_LIMIT_EVALUATOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CBAL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define CBAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CBAL_ASSERT_SAME(label, ante, cons, msg)
`define CBAL_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[src/cbal_pkg.sv]
// Shared constants, types and command structures of the cell balance evaluator.
package cbal_pkg;

  localparam int NUM_CELLS    = 24;
  localparam int MV_W         = 13;
  localparam int AVG_W        = 13;
  localparam int PACK_W       = 18;
  localparam int CELL_INDEX_W = 5;
  localparam int IDX_W        = $clog2(NUM_CELLS);
  localparam int SUM_W        = MV_W + $clog2(NUM_CELLS);
  localparam int AVG_SHIFT    = SUM_W + $clog2(NUM_CELLS);
  localparam int RECIP_W      = SUM_W + 1;
  localparam int PROD_W       = SUM_W + RECIP_W;

  // Rounded-up reciprocal of the cell count, exact for every sum of SUM_W bits.
  localparam logic [RECIP_W-1:0] AVG_RECIP =
    RECIP_W'(((longint'(1) << AVG_SHIFT) + longint'(NUM_CELLS) - 1) / longint'(NUM_CELLS));

  localparam logic [MV_W-1:0] START_RESET = MV_W'(30);
  localparam logic [MV_W-1:0] STOP_RESET  = MV_W'(15);
  localparam logic [MV_W-1:0] OVER_RESET  = MV_W'(4200);
  localparam logic [MV_W-1:0] UNDER_RESET = MV_W'(2800);

  typedef enum logic [1:0] {
    REG_START = 2'd0,
    REG_STOP  = 2'd1,
    REG_OVER  = 2'd2,
    REG_UNDER = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_OVER  = 2'd1,
    FAULT_UNDER = 2'd2
  } fault_t;

  typedef struct packed {
    logic [MV_W-1:0] start_mv;
    logic [MV_W-1:0] stop_mv;
    logic [MV_W-1:0] over_mv;
    logic [MV_W-1:0] under_mv;
  } cbal_cfg_t;

  typedef struct packed {
    logic             load;
    logic             load_last;
    logic [IDX_W-1:0] wr_addr;
    logic             div_step;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             out_load;
    logic [IDX_W-1:0] out_idx;
    logic             out_last;
  } cbal_cmd_t;

endpackage

[src/cell_balance_and_limit_evaluator_unit.sv]
// Top level of the cell balance and limit evaluator with its register port.
`include "cell_balance_and_limit_evaluator_unit_assert.svh"

// The block takes a scan of NUM_CELLS cell voltages (24 by default), one item
// per cycle while in_ready is high. After the last cell of a scan it forms the
// pack sum and the truncated average, then returns one result item per cell in
// index order, with the hysteresis balance decision and the limit flag. The
// average comes from a reciprocal multiplication in the cycle after the last
// cell, and results leave one per cycle from the cell memory while out_ready
// stays high. While the average step and the result sequence run, in_ready
// stays low; the next scan may be loaded while the last result of the
// previous one still waits.
module cell_balance_and_limit_evaluator_unit
  import cbal_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [3:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [MV_W-1:0]         cell_voltage_mv,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CELL_INDEX_W-1:0] cell_index,
  output logic                    balance_on,
  output logic                    balance_changed,
  output logic [1:0]              limit_fault,
  output logic [AVG_W-1:0]        average_mv,
  output logic [PACK_W-1:0]       pack_mv,
  output logic                    last_of_scan
);

  cbal_cfg_t cfg;
  cbal_cmd_t cmd;
  reg_idx_t  reg_sel;
  logic      cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_mv <= START_RESET;
      cfg.stop_mv  <= STOP_RESET;
      cfg.over_mv  <= OVER_RESET;
      cfg.under_mv <= UNDER_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_START: cfg.start_mv <= pwdata[MV_W-1:0];
        REG_STOP:  cfg.stop_mv  <= pwdata[MV_W-1:0];
        REG_OVER:  cfg.over_mv  <= pwdata[MV_W-1:0];
        REG_UNDER: cfg.under_mv <= pwdata[MV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_START: prdata = 32'(cfg.start_mv);
      REG_STOP:  prdata = 32'(cfg.stop_mv);
      REG_OVER:  prdata = 32'(cfg.over_mv);
      REG_UNDER: prdata = 32'(cfg.under_mv);
      default:   prdata = '0;
    endcase
  end

  cbal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  cbal_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd             (cmd),
    .cell_voltage_mv (cell_voltage_mv),
    .cell_index      (cell_index),
    .balance_on      (balance_on),
    .balance_changed (balance_changed),
    .limit_fault     (limit_fault),
    .average_mv      (average_mv),
    .pack_mv         (pack_mv),
    .last_of_scan    (last_of_scan)
  );

  `CBAL_ASSERT_SAME(a_no_load_in_div, cmd.div_step, !in_ready, "Input taken during division")
  `CBAL_ASSERT_NEXT(a_result_shown, cmd.out_load, out_valid, "Result not presented")
  `CBAL_ASSERT_SAME(a_last_index, out_valid && last_of_scan,
                    cell_index == CELL_INDEX_W'(NUM_CELLS - 1), "Last flag on wrong cell")
  `CBAL_ASSERT_SAME(a_fault_code, out_valid,
                    limit_fault != 2'd3, "Undefined limit fault code")

endmodule

[src/cbal_ctrl.sv]
// Controller: scan loading, average step sequencing and result emission.
module cbal_ctrl
  import cbal_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  output cbal_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_LOAD,
    S_DIV,
    S_EMIT
  } state_t;

  state_t              state;
  logic [IDX_W-1:0]    load_cnt;
  logic [IDX_W-1:0]    iss_idx;
  logic                iss_pending;
  logic                f_valid;
  logic [IDX_W-1:0]    f_idx;
  logic                o_valid;

  logic in_acc;
  logic adv;
  logic produce;
  logic fetch;
  logic last_load;
  logic f_last;

  assign in_ready  = (state == S_LOAD);
  assign out_valid = o_valid;
  assign in_acc    = in_valid && in_ready;
  assign adv       = !o_valid || out_ready;
  assign produce   = (state == S_EMIT) && f_valid && adv;
  assign fetch     = (state == S_EMIT) && iss_pending && (!f_valid || adv);
  assign last_load = (load_cnt == IDX_W'(NUM_CELLS - 1));
  assign f_last    = (f_idx == IDX_W'(NUM_CELLS - 1));

  always_comb begin
    cmd           = '0;
    cmd.load      = in_acc;
    cmd.load_last = in_acc && last_load;
    cmd.wr_addr   = load_cnt;
    cmd.div_step  = (state == S_DIV);
    cmd.rd_en     = fetch;
    cmd.rd_addr   = iss_idx;
    cmd.out_load  = produce;
    cmd.out_idx   = f_idx;
    cmd.out_last  = f_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      load_cnt    <= '0;
      iss_idx     <= '0;
      iss_pending <= 1'b0;
      f_valid     <= 1'b0;
      f_idx       <= '0;
      o_valid     <= 1'b0;
    end else begin
      if (produce) begin
        o_valid <= 1'b1;
      end else if (out_ready) begin
        o_valid <= 1'b0;
      end

      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (last_load) begin
              load_cnt <= '0;
              state    <= S_DIV;
            end else begin
              load_cnt <= load_cnt + IDX_W'(1);
            end
          end
        end
        S_DIV: begin
          iss_idx     <= '0;
          iss_pending <= 1'b1;
          f_valid     <= 1'b0;
          state       <= S_EMIT;
        end
        S_EMIT: begin
          if (fetch) begin
            f_valid <= 1'b1;
            f_idx   <= iss_idx;
            iss_idx <= iss_idx + IDX_W'(1);
            if (iss_idx == IDX_W'(NUM_CELLS - 1)) begin
              iss_pending <= 1'b0;
            end
          end else if (produce) begin
            f_valid <= 1'b0;
          end
          if (produce && f_last) begin
            state <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

[src/cbal_dp.sv]
// Datapath: cell memory, pack sum, reciprocal average, balance flags, results.
module cbal_dp
  import cbal_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  cbal_cfg_t               cfg,
  input  cbal_cmd_t               cmd,
  input  logic [MV_W-1:0]         cell_voltage_mv,
  output logic [CELL_INDEX_W-1:0] cell_index,
  output logic                    balance_on,
  output logic                    balance_changed,
  output logic [1:0]              limit_fault,
  output logic [AVG_W-1:0]        average_mv,
  output logic [PACK_W-1:0]       pack_mv,
  output logic                    last_of_scan
);

  logic [MV_W-1:0]      mem [NUM_CELLS];
  logic [MV_W-1:0]      rd_data;
  logic [SUM_W-1:0]     sum;
  logic [SUM_W-1:0]     sum_next;
  logic [SUM_W-1:0]     pack;
  logic [PROD_W-1:0]    avg_prod;
  logic [AVG_W-1:0]     quo;
  logic [NUM_CELLS-1:0] flags;

  logic                 was_on;
  logic                 now_on;
  logic signed [MV_W:0] excess;
  fault_t               fault;

  assign sum_next = sum + SUM_W'(cell_voltage_mv);
  assign avg_prod = PROD_W'(pack) * PROD_W'(AVG_RECIP);

  always_comb begin
    was_on = flags[cmd.out_idx];
    excess = $signed({1'b0, rd_data}) - $signed({1'b0, quo});
    if (was_on) begin
      now_on = excess > $signed({1'b0, cfg.stop_mv});
    end else begin
      now_on = excess > $signed({1'b0, cfg.start_mv});
    end
    if (rd_data >= cfg.over_mv) begin
      fault = FAULT_OVER;
    end else if (rd_data <= cfg.under_mv) begin
      fault = FAULT_UNDER;
    end else begin
      fault = FAULT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[cmd.wr_addr] <= cell_voltage_mv;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      flags <= '0;
    end else begin
      if (cmd.load) begin
        sum <= cmd.load_last ? '0 : sum_next;
      end
      if (cmd.out_load) begin
        flags[cmd.out_idx] <= now_on;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_last) begin
      pack <= sum_next;
    end
    if (cmd.div_step) begin
      quo <= avg_prod[AVG_SHIFT +: AVG_W];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cell_index      <= CELL_INDEX_W'(cmd.out_idx);
      balance_on      <= now_on;
      balance_changed <= now_on ^ was_on;
      limit_fault     <= fault;
      average_mv      <= quo;
      pack_mv         <= PACK_W'(pack);
      last_of_scan    <= cmd.out_last;
    end
  end

endmodule

[tb/cell_balance_and_limit_evaluator_unit_tb.sv]
// Self-checking testbench for the cell balance and limit evaluator unit.
`timescale 1ns / 1ps

module cell_balance_and_limit_evaluator_unit_tb;
  import cbal_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD = 120;
  localparam int HOLD_AFTER_RESULTS = 30;
  localparam logic [AVG_W-1:0] DIRECTED_AVG = AVG_W'(3500);
  localparam logic [PACK_W-1:0] DIRECTED_PACK = PACK_W'(84000);

  typedef struct packed {
    logic [CELL_INDEX_W-1:0] idx;
    logic                    on;
    logic                    changed;
    fault_t                  fault;
    logic [AVG_W-1:0]        avg;
    logic [PACK_W-1:0]       pack;
    logic                    last;
  } cell_result_t;

  typedef struct packed {
    logic [MV_W-1:0] mv;
    logic            on;
    logic            changed;
    fault_t          fault;
  } directed_row_t;

  logic                    clk;
  logic                    rst;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [3:0]              paddr;
  logic [31:0]             pwdata;
  logic [31:0]             prdata;
  logic                    pready;
  logic                    in_valid;
  logic                    in_ready;
  logic [MV_W-1:0]         cell_voltage_mv;
  logic                    out_valid;
  logic                    out_ready;
  logic [CELL_INDEX_W-1:0] cell_index;
  logic                    balance_on;
  logic                    balance_changed;
  logic [1:0]              limit_fault;
  logic [AVG_W-1:0]        average_mv;
  logic [PACK_W-1:0]       pack_mv;
  logic                    last_of_scan;

  // Predictor state.
  logic [MV_W-1:0] start_mv;
  logic [MV_W-1:0] stop_mv;
  logic [MV_W-1:0] over_mv;
  logic [MV_W-1:0] under_mv;
  logic [MV_W-1:0] scan_store [NUM_CELLS];
  logic            bleed_flags [NUM_CELLS];
  int unsigned     scan_sum;
  int              cells_in_scan;
  cell_result_t    expected_results [$];

  int  mismatches = 0;
  int  results_seen = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;
  bit  held = 1'b0;

  // One scan at reset thresholds: average 3500, every result read off directly.
  directed_row_t directed_scan [NUM_CELLS] = '{
    '{13'd0,    1'b0, 1'b0, FAULT_UNDER},
    '{13'd8191, 1'b1, 1'b1, FAULT_OVER},
    '{13'd4200, 1'b1, 1'b1, FAULT_OVER},
    '{13'd4199, 1'b1, 1'b1, FAULT_NONE},
    '{13'd2800, 1'b0, 1'b0, FAULT_UNDER},
    '{13'd2801, 1'b0, 1'b0, FAULT_NONE},
    '{13'd3530, 1'b0, 1'b0, FAULT_NONE},
    '{13'd3531, 1'b1, 1'b1, FAULT_NONE},
    '{13'd3500, 1'b0, 1'b0, FAULT_NONE},
    '{13'd3500, 1'b0, 1'b0, FAULT_NONE},
    '{13'd3500, 1'b0, 1'b0, FAULT_NONE},
    '{13'd3500, 1'b0, 1'b0, FAULT_NONE},
    '{13'd3500, 1'b0, 1'b0, FAULT_NONE},
    '{13'd3500, 1'b0, 1'b0, FAULT_NONE},
    '{13'd3500, 1'b0, 1'b0, FAULT_NONE},
    '{13'd3500, 1'b0, 1'b0, FAULT_NONE},
    '{13'd3500, 1'b0, 1'b0, FAULT_NONE},
    '{13'd3500, 1'b0, 1'b0, FAULT_NONE},
    '{13'd3500, 1'b0, 1'b0, FAULT_NONE},
    '{13'd3500, 1'b0, 1'b0, FAULT_NONE},
    '{13'd3500, 1'b0, 1'b0, FAULT_NONE},
    '{13'd3500, 1'b0, 1'b0, FAULT_NONE},
    '{13'd3500, 1'b0, 1'b0, FAULT_NONE},
    '{13'd2248, 1'b0, 1'b0, FAULT_UNDER}
  };

  cell_balance_and_limit_evaluator_unit DUT (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .cell_voltage_mv (cell_voltage_mv),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cell_index      (cell_index),
    .balance_on      (balance_on),
    .balance_changed (balance_changed),
    .limit_fault     (limit_fault),
    .average_mv      (average_mv),
    .pack_mv         (pack_mv),
    .last_of_scan    (last_of_scan)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stores one cell and, on the last cell of a scan, queues the decisions for all cells.
  task automatic evaluate_cell(input logic [MV_W-1:0] mv);
    int unsigned avg;
    int excess;
    int i;
    logic now_on;
    cell_result_t r;
    scan_store[cells_in_scan] = mv;
    scan_sum += mv;
    cells_in_scan++;
    if (cells_in_scan == NUM_CELLS) begin
      avg = scan_sum / NUM_CELLS;
      for (i = 0; i < NUM_CELLS; i++) begin
        excess = int'(scan_store[i]) - int'(avg);
        if (bleed_flags[i]) begin
          now_on = excess > int'(stop_mv);
        end else begin
          now_on = excess > int'(start_mv);
        end
        r.idx = CELL_INDEX_W'(i);
        r.on = now_on;
        r.changed = now_on != bleed_flags[i];
        if (scan_store[i] >= over_mv) begin
          r.fault = FAULT_OVER;
        end else if (scan_store[i] <= under_mv) begin
          r.fault = FAULT_UNDER;
        end else begin
          r.fault = FAULT_NONE;
        end
        r.avg = AVG_W'(avg);
        r.pack = PACK_W'(scan_sum);
        r.last = (i == NUM_CELLS - 1);
        bleed_flags[i] = now_on;
        expected_results.push_back(r);
      end
      scan_sum = 0;
      cells_in_scan = 0;
    end
  endtask

  task automatic reg_access(input reg_idx_t idx, input logic wr, input logic [MV_W-1:0] value,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic write_threshold(input reg_idx_t idx, input logic [MV_W-1:0] value);
    logic [31:0] rdata;
    reg_access(idx, 1'b1, value, rdata);
    case (idx)
      REG_START: start_mv = value;
      REG_STOP:  stop_mv = value;
      REG_OVER:  over_mv = value;
      REG_UNDER: under_mv = value;
    endcase
    reg_access(idx, 1'b0, '0, rdata);
    if (rdata !== 32'(value)) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("register %s readback: expected %0d, got %0d", idx.name(), value, rdata);
      end
    end
  endtask

  task automatic set_thresholds(input logic [MV_W-1:0] st, input logic [MV_W-1:0] sp,
                                input logic [MV_W-1:0] ov, input logic [MV_W-1:0] un);
    write_threshold(REG_START, st);
    write_threshold(REG_STOP, sp);
    write_threshold(REG_OVER, ov);
    write_threshold(REG_UNDER, un);
  endtask

  task automatic send_cell(input logic [MV_W-1:0] mv);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    cell_voltage_mv <= mv;
    do @(posedge clk); while (!in_ready);
    evaluate_cell(mv);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Cells cluster around the center, mostly within a few tens of millivolts so
  // that both hysteresis thresholds are crossed, with occasional wide scans.
  task automatic run_scans(input int scans, input int center);
    int s;
    int c;
    int mode;
    int spread;
    int pick;
    int v;
    for (s = 0; s < scans; s++) begin
      mode = $urandom_range(0, 9);
      spread = (mode < 6) ? $urandom_range(0, 60) : $urandom_range(100, 600);
      for (c = 0; c < NUM_CELLS; c++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          v = 0;
        end else if (pick == 1) begin
          v = 8191;
        end else if (pick == 2 || mode == 9) begin
          v = $urandom_range(0, 8191);
        end else begin
          v = center + $urandom_range(0, 2 * spread) - spread;
          if (v < 0) v = 0;
          if (v > 8191) v = 8191;
        end
        send_cell(MV_W'(v));
      end
    end
  endtask

  always @(posedge clk) begin : result_monitor
    cell_result_t got;
    cell_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      got = '{cell_index, balance_on, balance_changed, fault_t'(limit_fault), average_mv,
              pack_mv, last_of_scan};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result item for cell %0d", cell_index);
        end
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("expected idx=%0d on=%0b chg=%0b flt=%0d avg=%0d pack=%0d last=%0b",
                     want.idx, want.on, want.changed, want.fault, want.avg, want.pack,
                     want.last);
            $display("got      idx=%0d on=%0b chg=%0b flt=%0d avg=%0d pack=%0d last=%0b",
                     got.idx, got.on, got.changed, limit_fault, got.avg, got.pack,
                     got.last);
          end
        end
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AFTER_RESULTS) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        held = 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int i;
    int p;
    int center;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    cell_voltage_mv = '0;
    start_mv = START_RESET;
    stop_mv = STOP_RESET;
    over_mv = OVER_RESET;
    under_mv = UNDER_RESET;
    for (i = 0; i < NUM_CELLS; i++) begin
      bleed_flags[i] = 1'b0;
      scan_store[i] = '0;
    end
    scan_sum = 0;
    cells_in_scan = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < NUM_CELLS; i++) begin
      send_cell(directed_scan[i].mv);
    end
    for (i = 0; i < NUM_CELLS; i++) begin
      expected_results[i] = '{CELL_INDEX_W'(i), directed_scan[i].on, directed_scan[i].changed,
                              directed_scan[i].fault, DIRECTED_AVG, DIRECTED_PACK,
                              i == NUM_CELLS - 1};
    end

    // The long receiver hold-off falls inside the first of these scans.
    run_scans(2, 3500);
    drain_results();

    // Every cell is over the limit, and overvoltage wins over undervoltage.
    set_thresholds(13'd0, 13'd0, 13'd0, 13'd8191);
    run_scans(1, $urandom_range(500, 7500));
    drain_results();

    set_thresholds(13'd8191, 13'd8191, 13'd8191, 13'd0);
    run_scans(1, $urandom_range(500, 7500));
    drain_results();

    for (p = 0; p < 3; p++) begin
      center = $urandom_range(1500, 5500);
      set_thresholds(MV_W'($urandom_range(0, 60)), MV_W'($urandom_range(0, 60)),
                     MV_W'(center + $urandom_range(0, 100)),
                     MV_W'(center - $urandom_range(0, 100)));
      if (p >= 2) quiet = 1'b1;
      run_scans(1, center);
      drain_results();
    end

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/cbal_pkg.sv
src/cbal_ctrl.sv
src/cbal_dp.sv
src/cell_balance_and_limit_evaluator_unit.sv
tb/cell_balance_and_limit_evaluator_unit_tb.sv
